[hdl/square_path_heading_sequencer_core_defines.svh]
// assertion macros for the square path heading sequencer
`ifndef SQUARE_PATH_HEADING_SEQUENCER_CORE_DEFINES_SVH
`define SQUARE_PATH_HEADING_SEQUENCER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked on every clock edge once reset is released
`define SPHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked on every clock edge, reset included
`define SPHS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SPHS_ASSERT(label, prop, msg)
`define SPHS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[hdl/sphs_pkg.sv]
package sphs_pkg;

  // fraction bits of angles and commands
  localparam int unsigned AngleFracBits = 12;

  localparam int unsigned HeadingW = 16;
  localparam int unsigned CmdW     = 16;
  localparam int unsigned SpeedW   = 15;
  localparam int unsigned TolW     = 15;
  localparam int unsigned GainW    = 8;
  localparam int unsigned TicksW   = 10;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned CfgIdxW  = 2;

  // heading error and rounded product widths
  localparam int unsigned ErrW    = 18;
  localparam int unsigned ErrMagW = ErrW - 1;
  localparam int unsigned ProdW   = ErrW + GainW + 1;
  localparam int unsigned ScaledW = ProdW - 8;

  // rounded targets
  localparam longint unsigned HalfPiRaw =
    ((64'd15708 << AngleFracBits) + 64'd5000) / 64'd10000;
  localparam longint unsigned PiRaw =
    ((64'd314159 << AngleFracBits) + 64'd50000) / 64'd100000;
  localparam logic signed [ErrW-1:0] HalfPiQ = ErrW'(HalfPiRaw);
  localparam logic signed [ErrW-1:0] PiQ     = ErrW'(PiRaw);

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADING_GAIN      = 2'd0,
    CFG_DRIVE_SPEED       = 2'd1,
    CFG_HEADING_TOLERANCE = 2'd2,
    CFG_LEG_TICKS         = 2'd3
  } cfg_idx_e;

  localparam logic [GainW-1:0]  GainRst   = 8'd179;
  localparam logic [SpeedW-1:0] SpeedRst  = 15'd819;
  localparam logic [TolW-1:0]   TolRst    = 15'd410;
  localparam logic [TicksW-1:0] TicksRst  = 10'd100;

  // path modes: even ones turn, odd ones drive
  typedef enum logic [2:0] {
    MODE_TURN0    = 3'd0,
    MODE_DRIVE0   = 3'd1,
    MODE_TURN90   = 3'd2,
    MODE_DRIVE90  = 3'd3,
    MODE_TURN180  = 3'd4,
    MODE_DRIVE180 = 3'd5,
    MODE_TURN270  = 3'd6,
    MODE_DRIVE270 = 3'd7
  } mode_e;

endpackage

[hdl/square_path_heading_sequencer_core.sv]
// square path heading sequencer
//
// input channel: one item per control tick, carrying pose_seen_i and the
// signed q3.12 heading_i, taken at a clock edge with in_valid_i high and
// in_stall_o low. an item with pose_seen_i low is taken and dropped: no
// result and no change of the path mode or leg count.
// output channel: one item per tick with a pose, holding linear_cmd_o,
// angular_cmd_o and the mode after the tick, taken when out_valid_o is
// high and out_stall_i is low.
// configuration: cfg_we_i writes cfg_data_i into the register picked by
// cfg_idx_i; write only while no item is in flight.
// each item passes through the input register, then one pass of error,
// gain multiply, saturation and mode update into the result register.
// throughput: one item per cycle while the receiver does not stall, set by
// the single 9x18 multiply between the two registers.
// a stalled receiver holds the result register; the input register still
// takes one more item, after which in_stall_o follows out_stall_i.
// reset: mode 0 (turn to heading zero), leg count 0, registers at their
// defaults, both pipeline stages empty.
`include "square_path_heading_sequencer_core_defines.svh"

module square_path_heading_sequencer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [sphs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [sphs_pkg::CfgDataW-1:0]    cfg_data_i,
  // input items
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             pose_seen_i,
  input  logic signed [sphs_pkg::HeadingW-1:0] heading_i,
  // result items
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sphs_pkg::SpeedW-1:0]      linear_cmd_o,
  output logic signed [sphs_pkg::CmdW-1:0] angular_cmd_o,
  output logic [2:0]                       mode_o
);
  import sphs_pkg::*;

  // configuration registers
  logic [GainW-1:0]  gain_q;
  logic [SpeedW-1:0] speed_q;
  logic [TolW-1:0]   tol_q;
  logic [TicksW-1:0] ticks_q;

  // sequencer state
  mode_e             mode_q, mode_d;
  logic [TicksW-1:0] leg_q, leg_d;

  // input stage (only ticks with a pose are kept)
  logic                       in_vld_q;
  logic signed [HeadingW-1:0] heading_q;

  // result stage
  logic                     out_vld_q;
  logic [SpeedW-1:0]        lin_q, lin_d;
  logic signed [CmdW-1:0]   ang_q, ang_d;
  mode_e                    out_mode_q;

  logic in_take;
  logic adv;

  // datapath signals
  logic signed [HeadingW:0] h_ext;
  logic signed [HeadingW:0] h_abs;
  logic signed [ErrW-1:0]   err;
  logic [ErrMagW-1:0]       err_mag;
  logic signed [ProdW-1:0]  gain_w, err_w, prod;
  logic signed [ScaledW-1:0] scaled, ang_pre;
  logic [TicksW-1:0]        leg_inc, leg_lim;
  logic                     turn_done;

  // the result register loads when the input stage holds an item and the result register is empty or its item is taken
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  // heading error against the current leg's target
  always_comb begin
    h_ext = (HeadingW + 1)'(heading_q);
    h_abs = heading_q[HeadingW-1] ? -h_ext : h_ext;
    unique case (mode_q)
      MODE_TURN0, MODE_DRIVE0:     err = -ErrW'(h_ext);
      MODE_TURN90, MODE_DRIVE90:   err = HalfPiQ - ErrW'(h_ext);
      MODE_TURN180, MODE_DRIVE180: err = PiQ - ErrW'(h_abs);
      MODE_TURN270, MODE_DRIVE270: err = -HalfPiQ - ErrW'(h_ext);
      default:                     err = '0;
    endcase
    err_mag = err[ErrW-1] ? ErrMagW'(-err) : ErrMagW'(err);
  end

  // proportional term, rounded to nearest with halves up, then saturated
  always_comb begin
    gain_w = ProdW'({1'b0, gain_q});
    err_w  = ProdW'(err);
    prod   = gain_w * err_w + ProdW'(128);
    scaled = prod[ProdW-1:8];
    // the pi turn steers by the mirrored error when heading is negative
    if (mode_q == MODE_TURN180 && heading_q[HeadingW-1]) begin
      ang_pre = -scaled;
    end else begin
      ang_pre = scaled;
    end
    priority if (ang_pre > ScaledW'(32767)) begin
      ang_d = 16'sh7fff;
    end else if (ang_pre < -ScaledW'(32768)) begin
      ang_d = -16'sh8000;
    end else begin
      ang_d = ang_pre[CmdW-1:0];
    end
    lin_d = mode_q[0] ? speed_q : '0;
  end

  // mode and leg count update
  always_comb begin
    leg_inc   = leg_q + TicksW'(1);
    leg_lim   = (ticks_q == '0) ? TicksW'(1) : ticks_q;
    turn_done = (err_mag < ErrMagW'(tol_q));
    mode_d    = mode_q;
    leg_d     = leg_q;
    if (mode_q[0]) begin
      if (leg_inc >= leg_lim) begin
        leg_d  = '0;
        mode_d = mode_e'(mode_q + 3'd1);
      end else begin
        leg_d  = leg_inc;
      end
    end else if (turn_done) begin
      mode_d = mode_e'(mode_q + 3'd1);
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GainRst;
      speed_q <= SpeedRst;
      tol_q   <= TolRst;
      ticks_q <= TicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HEADING_GAIN:      gain_q  <= cfg_data_i[GainW-1:0];
        CFG_DRIVE_SPEED:       speed_q <= cfg_data_i[SpeedW-1:0];
        CFG_HEADING_TOLERANCE: tol_q   <= cfg_data_i[TolW-1:0];
        CFG_LEG_TICKS:         ticks_q <= cfg_data_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  // control state of both stages and the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= MODE_TURN0;
      leg_q     <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= pose_seen_i;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        mode_q    <= mode_d;
        leg_q     <= leg_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      heading_q <= heading_i;
    end
    if (adv) begin
      lin_q      <= lin_d;
      ang_q      <= ang_d;
      out_mode_q <= mode_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign linear_cmd_o  = lin_q;
  assign angular_cmd_o = ang_q;
  assign mode_o        = out_mode_q;

  // the leg counter only runs in drive modes
  `SPHS_ASSERT(a_leg_in_drive, (leg_q != '0) |-> mode_q[0], "leg count set in a turn mode")
  // the last result shows the mode the sequencer now holds
  `SPHS_ASSERT(a_mode_shown, adv |=> (out_mode_q == mode_q), "result mode differs from state")
  // the mode moves only when an item passes into the result register
  `SPHS_ASSERT(a_mode_moves, !$stable(mode_q) |-> $past(adv), "mode changed without an item")

endmodule

[dv/sphs_command_checker.sv]
`timescale 1ns / 100ps

module sphs_command_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sphs_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [sphs_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic                                 pose_seen_i,
  input  logic signed [sphs_pkg::HeadingW-1:0] heading_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic [sphs_pkg::SpeedW-1:0]          linear_cmd_i,
  input  logic signed [sphs_pkg::CmdW-1:0]     angular_cmd_i,
  input  logic [2:0]                           mode_i,
  output int                                   pending_o,
  output int                                   fail_count_o
);
  import sphs_pkg::*;

  localparam int HalfPiTarget =
    int'(((64'd15708 << AngleFracBits) + 64'd5000) / 64'd10000);
  localparam int PiTarget =
    int'(((64'd314159 << AngleFracBits) + 64'd50000) / 64'd100000);

  localparam logic [GainW-1:0]  GainAtReset  = 8'd179;
  localparam logic [SpeedW-1:0] SpeedAtReset = 15'd819;
  localparam logic [TolW-1:0]   TolAtReset   = 15'd410;
  localparam logic [TicksW-1:0] TicksAtReset = 10'd100;

  typedef struct packed {
    logic [SpeedW-1:0]      linear;
    logic signed [CmdW-1:0] angular;
    mode_e                  mode;
  } path_cmd_t;

  // own copy of the registers and the sequencer state
  logic [GainW-1:0]  gain_q;
  logic [SpeedW-1:0] speed_q;
  logic [TolW-1:0]   tol_q;
  logic [TicksW-1:0] ticks_q;
  mode_e             path_mode;
  logic [TicksW-1:0] leg_count;

  path_cmd_t cmds_due[$];
  path_cmd_t want;
  int        n_errors = 0;

  assign fail_count_o = n_errors;

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch, %s", $time, what);
    n_errors++;
  endtask

  // one tick with a pose: command from the mode held before, then mode update
  function automatic path_cmd_t steer_tick(input logic signed [HeadingW-1:0] hdg);
    path_cmd_t cmd;
    int        h;
    int        err;
    int        steer;
    int        lim;
    h = int'(hdg);
    case (path_mode)
      MODE_TURN0, MODE_DRIVE0:     err = -h;
      MODE_TURN90, MODE_DRIVE90:   err = HalfPiTarget - h;
      MODE_TURN180, MODE_DRIVE180: err = PiTarget - ((h < 0) ? -h : h);
      default:                     err = -HalfPiTarget - h;
    endcase
    // q0.8 gain, half up; the arithmetic shift floors
    steer = (int'(gain_q) * err + 128) >>> 8;
    if (path_mode == MODE_TURN180 && h < 0) steer = -steer;
    if (steer > 32767) steer = 32767;
    else if (steer < -32768) steer = -32768;
    cmd.angular = CmdW'(steer);
    cmd.linear  = path_mode[0] ? speed_q : '0;
    if (path_mode[0]) begin
      lim = (ticks_q == '0) ? 1 : int'(ticks_q);
      leg_count = leg_count + 1'b1;
      if (int'(leg_count) >= lim) begin
        leg_count = '0;
        path_mode = mode_e'(path_mode + 3'd1);
      end
    end else if (((err < 0) ? -err : err) < int'(tol_q)) begin
      path_mode = mode_e'(path_mode + 3'd1);
    end
    cmd.mode = path_mode;
    return cmd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    = GainAtReset;
      speed_q   = SpeedAtReset;
      tol_q     = TolAtReset;
      ticks_q   = TicksAtReset;
      path_mode = MODE_TURN0;
      leg_count = '0;
      cmds_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_HEADING_GAIN:      gain_q  = cfg_data_i[GainW-1:0];
          CFG_DRIVE_SPEED:       speed_q = cfg_data_i[SpeedW-1:0];
          CFG_HEADING_TOLERANCE: tol_q   = cfg_data_i[TolW-1:0];
          default:               ticks_q = cfg_data_i[TicksW-1:0];
        endcase
      end
      if (in_valid_i && !in_stall_i && pose_seen_i) cmds_due.push_back(steer_tick(heading_i));
      if (out_valid_i && !out_stall_i) begin
        if (cmds_due.size() == 0) begin
          flag_mismatch("result with no tick waiting");
        end else begin
          want = cmds_due.pop_front();
          if (linear_cmd_i !== want.linear)
            flag_mismatch($sformatf("linear_cmd got %0d want %0d", linear_cmd_i, want.linear));
          if (angular_cmd_i !== want.angular)
            flag_mismatch($sformatf("angular_cmd got %0d want %0d",
                                    angular_cmd_i, want.angular));
          if (mode_i !== want.mode)
            flag_mismatch($sformatf("mode got %0d want %0d", mode_i, want.mode));
        end
      end
      pending_o <= cmds_due.size();
    end
  end

endmodule

[dv/square_path_heading_sequencer_core_tb.sv]
`timescale 1ns / 100ps

module square_path_heading_sequencer_core_tb;
  import sphs_pkg::*;

  // heading targets, used only to aim the stimulus near turn ends
  localparam int AimHalfPi =
    int'(((64'd15708 << AngleFracBits) + 64'd5000) / 64'd10000);
  localparam int AimPi =
    int'(((64'd314159 << AngleFracBits) + 64'd50000) / 64'd100000);

  // watchdog, far beyond the slowest correct run
  localparam int TimeLimitNs = 2_000_000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // every input known from time zero
  logic                       cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]         cfg_idx   = '0;
  logic [CfgDataW-1:0]        cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic                       pose_seen = 1'b0;
  logic signed [HeadingW-1:0] heading   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [SpeedW-1:0]          linear_cmd;
  logic signed [CmdW-1:0]     angular_cmd;
  logic [2:0]                 mode;

  int cmds_waiting;
  int mismatches;

  // calm: no idling on either side; hold_req: ask the receiver for a long hold-off
  bit calm      = 1'b0;
  bit hold_req  = 1'b0;
  int hold_left = 0;

  always #4 clk = ~clk;

  square_path_heading_sequencer_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pose_seen_i  (pose_seen),
    .heading_i    (heading),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .linear_cmd_o (linear_cmd),
    .angular_cmd_o(angular_cmd),
    .mode_o       (mode)
  );

  sphs_command_checker cmd_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .pose_seen_i  (pose_seen),
    .heading_i    (heading),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .linear_cmd_i (linear_cmd),
    .angular_cmd_i(angular_cmd),
    .mode_i       (mode),
    .pending_o    (cmds_waiting),
    .fail_count_o (mismatches)
  );

  // receiver: random stalls, a counted long hold-off on request, none when calm
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 90;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 24);
    end
  end

  initial begin
    #(TimeLimitNs);
    $display("** square_path_heading_sequencer_core: FAILED **");
    $finish;
  end

  // offer one item, with random idle cycles ahead of it; returns on acceptance
  task automatic send_tick(input logic pose, input logic [HeadingW-1:0] hdg);
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    pose_seen <= pose;
    heading   <= hdg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending, wait for every result, then let a skipped item drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cmds_waiting != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // all four registers on successive edges; spare data bits are random
  task automatic program_regs(input logic [GainW-1:0] g, input logic [SpeedW-1:0] s,
                              input logic [TolW-1:0] t, input logic [TicksW-1:0] n);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_HEADING_GAIN;
    cfg_data <= {(CfgDataW-GainW)'($urandom), g};
    @(posedge clk);
    cfg_idx  <= CFG_DRIVE_SPEED;
    cfg_data <= s;
    @(posedge clk);
    cfg_idx  <= CFG_HEADING_TOLERANCE;
    cfg_data <= t;
    @(posedge clk);
    cfg_idx  <= CFG_LEG_TICKS;
    cfg_data <= {(CfgDataW-TicksW)'($urandom), n};
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // half the headings sit near one of the turn targets, the rest anywhere
  function automatic logic [HeadingW-1:0] pick_heading();
    int aim;
    int wobble;
    case ($urandom_range(0, 4))
      0:       aim = 0;
      1:       aim = AimHalfPi;
      2:       aim = -AimHalfPi;
      3:       aim = AimPi;
      default: aim = -AimPi;
    endcase
    wobble = int'($urandom_range(0, 1400)) - 700;
    if ($urandom_range(0, 99) < 50) return HeadingW'(aim + wobble);
    return HeadingW'($urandom);
  endfunction

  initial begin
    int unsigned ticks_sent;
    logic        pose;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: turn to zero with extreme headings, tolerance edge
    send_tick(1'b1, HeadingW'(32767));
    send_tick(1'b1, HeadingW'(-32768));
    send_tick(1'b0, HeadingW'($urandom));
    send_tick(1'b1, HeadingW'(410));
    send_tick(1'b1, HeadingW'(-409));
    // first drive tick at the default speed and leg length
    send_tick(1'b1, HeadingW'(1234));
    settle();

    // full gain and speed, leg length zero acts as one, and the count is past it
    program_regs(8'd255, 15'd32767, 15'd410, 10'd0);
    send_tick(1'b1, HeadingW'(-32768));
    // turn to +pi/2: positive saturation, just outside then just inside
    send_tick(1'b1, HeadingW'(-32768));
    send_tick(1'b1, HeadingW'(AimHalfPi - 410));
    send_tick(1'b1, HeadingW'(AimHalfPi + 409));
    send_tick(1'b1, HeadingW'(32767));
    // turn to pi: negative headings flip the command, skipped tick in between
    send_tick(1'b1, HeadingW'(-1));
    send_tick(1'b1, HeadingW'(-32768));
    send_tick(1'b1, HeadingW'(32767));
    send_tick(1'b0, HeadingW'($urandom));
    send_tick(1'b1, HeadingW'(-AimPi));
    // pi drive leg does not flip
    send_tick(1'b1, HeadingW'(-5000));
    // turn to -pi/2: negative saturation
    send_tick(1'b1, HeadingW'(32767));
    send_tick(1'b1, HeadingW'(-AimHalfPi));
    send_tick(1'b1, HeadingW'(0));
    settle();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0:       program_regs(8'd255, 15'd32767, 15'd32767, 10'd1);
        1:       program_regs(8'd0, 15'd0, 15'd0, 10'd1023);
        2:       program_regs(8'd1, 15'd1, 15'd700, 10'd2);
        6:       program_regs(GainW'($urandom), SpeedW'($urandom),
                              TolW'($urandom_range(100, 2500)), 10'd100);
        8:       program_regs(GainW'($urandom), SpeedW'($urandom), TolW'($urandom),
                              TicksW'($urandom_range(1, 12)));
        // zero tolerance with one-tick legs: ends up stuck in a turn
        9:       program_regs(GainW'($urandom), SpeedW'($urandom), 15'd0, 10'd0);
        default: program_regs(GainW'($urandom), SpeedW'($urandom),
                              TolW'($urandom_range(100, 2500)),
                              TicksW'($urandom_range(1, 12)));
      endcase
      calm = (phase == 7);
      // long receiver hold-off while items keep coming, so the input backs up
      if (phase == 4) hold_req = 1'b1;
      ticks_sent = 0;
      while (ticks_sent < 100) begin
        pose = ($urandom_range(0, 9) != 0);
        send_tick(pose, pick_heading());
        if (pose) ticks_sent++;
      end
      settle();
    end
    calm = 1'b0;

    if (mismatches == 0) begin
      $display("** square_path_heading_sequencer_core: PASSED **");
    end else begin
      $display("** square_path_heading_sequencer_core: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/sphs_pkg.sv
hdl/square_path_heading_sequencer_core.sv
dv/sphs_command_checker.sv
dv/square_path_heading_sequencer_core_tb.sv
